FILE: rtl/scse_pkg.sv
// ---------------------------------------------------------------------------
// scse_pkg
// Shared types, codes and helpers for the string compare / scan engine.
// ---------------------------------------------------------------------------
package scse_pkg;

  // Request codes on the input channel
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_ELEM  = 1'b1;

  // Element width codes
  typedef logic [1:0] wcode_t;
  localparam wcode_t WCODE_B = 2'd0;
  localparam wcode_t WCODE_W = 2'd1;
  localparam wcode_t WCODE_D = 2'd2;
  localparam wcode_t WCODE_Q = 2'd3;

  // Command queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Classification made by the front end
  typedef enum logic [1:0] {
    CMD_START       = 2'd0,
    CMD_START_EMPTY = 2'd1,
    CMD_ELEM        = 2'd2
  } cmd_kind_t;

  // One queued command. For a start, word_a is the accumulator and word_b is
  // unused; for an element, word_a/word_b are the source/destination values.
  typedef struct packed {
    cmd_kind_t   kind;
    wcode_t      code;
    logic        scan;
    logic        soe;
    logic        rep;
    logic        back;
    logic [63:0] count;
    logic [63:0] src_addr;
    logic [63:0] dst_addr;
    logic [63:0] word_a;
    logic [63:0] word_b;
  } cmd_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic wcode_t width_code(input logic [3:0] nbytes);
    wcode_t c;
    unique case (nbytes)
      4'd1:    c = WCODE_B;
      4'd2:    c = WCODE_W;
      4'd4:    c = WCODE_D;
      default: c = WCODE_Q;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] width_mask(input wcode_t c);
    logic [63:0] m;
    unique case (c)
      WCODE_B: m = 64'h0000_0000_0000_00ff;
      WCODE_W: m = 64'h0000_0000_0000_ffff;
      WCODE_D: m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] width_stride(input wcode_t c);
    logic [63:0] s;
    unique case (c)
      WCODE_B: s = 64'd1;
      WCODE_W: s = 64'd2;
      WCODE_D: s = 64'd4;
      default: s = 64'd8;
    endcase
    return s;
  endfunction

  function automatic logic sign_bit(input logic [63:0] v, input wcode_t c);
    logic s;
    unique case (c)
      WCODE_B: s = v[7];
      WCODE_W: s = v[15];
      WCODE_D: s = v[31];
      default: s = v[63];
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/scse_front.sv
// ---------------------------------------------------------------------------
// scse_front
// Input stage: accept items, classify them and hand them to the queue.
// ---------------------------------------------------------------------------
module scse_front import scse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [3:0]  in_elem_bytes,
  input  logic        in_is_scan,
  input  logic        in_stop_on_equal,
  input  logic        in_is_rep,
  input  logic        in_backward,
  input  logic [63:0] in_count,
  input  logic [63:0] in_src_addr,
  input  logic [63:0] in_dst_addr,
  input  logic [63:0] in_accumulator,
  input  logic [63:0] in_src_value,
  input  logic [63:0] in_dst_value,
  input  q_stat_t     q_stat,
  output logic        push_valid,
  output cmd_t        push_cmd
);

  logic fv_r, fv_nxt;
  cmd_t cmd_r;
  cmd_t dec;
  logic accept;
  logic handoff;

  always_comb begin
    dec          = '0;
    dec.code     = width_code(in_elem_bytes);
    dec.scan     = in_is_scan;
    dec.soe      = in_stop_on_equal;
    dec.rep      = in_is_rep;
    dec.back     = in_backward;
    dec.count    = in_count;
    dec.src_addr = in_src_addr;
    dec.dst_addr = in_dst_addr;
    if (in_req_type == REQ_START) begin
      dec.kind   = (in_is_rep && (in_count == 64'd0)) ? CMD_START_EMPTY : CMD_START;
      dec.word_a = in_accumulator;
      dec.word_b = '0;
    end else begin
      dec.kind   = CMD_ELEM;
      dec.word_a = in_src_value;
      dec.word_b = in_dst_value;
    end
  end

  assign handoff  = fv_r && !q_stat.full;
  assign in_stall = fv_r && q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (handoff) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= dec;
    end
  end

  assign push_valid = fv_r;
  assign push_cmd   = cmd_r;

endmodule

FILE: rtl/scse_queue.sv
// ---------------------------------------------------------------------------
// scse_queue
// Short command queue between the front and back ends.
// ---------------------------------------------------------------------------
module scse_queue import scse_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output q_stat_t q_stat,
  output cmd_t    head_cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop_ok;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.valid = (cnt_r != '0);
  assign push   = push_valid && !q_stat.full;
  assign pop_ok = pop && q_stat.valid;

  always_comb begin
    wptr_nxt = push   ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop_ok ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_cmd;
    end
  end

  assign head_cmd = mem[rptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/scse_back.sv
// ---------------------------------------------------------------------------
// scse_back
// Execution stage: instruction state, per-element compare and result register.
// ---------------------------------------------------------------------------
module scse_back import scse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  cmd_t        head_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_done_res,
  output logic        out_flags_written,
  output logic [63:0] out_count_left,
  output logic [63:0] out_src_addr_out,
  output logic [63:0] out_dst_addr_out,
  output logic [3:0]  out_nzcv
);

  // Instruction state
  logic        busy_r, busy_nxt;
  wcode_t      code_r;
  logic        scan_r, soe_r, rep_r, back_r;
  logic [63:0] rem_r, saved_r, sptr_r, dptr_r, acc_r;

  // Result register
  logic        ov_r, ov_nxt;
  logic        done_r, fw_r;
  logic [63:0] cl_r, so_r, do_r;
  logic [3:0]  nzcv_r;

  // Element datapath
  logic [63:0] m, stride, a, b, rem_dec, sp_step, dp_step, sp_res, diff;
  logic        borrow, eq, done, emit;
  logic [3:0]  flags;

  assign pop = q_stat.valid && (!ov_r || !out_stall);

  always_comb begin
    m       = width_mask(code_r);
    stride  = width_stride(code_r);
    a       = scan_r ? acc_r : (head_cmd.word_a & m);
    b       = head_cmd.word_b & m;
    eq      = (a == b);
    sp_step = back_r ? sptr_r - stride : sptr_r + stride;
    dp_step = back_r ? dptr_r - stride : dptr_r + stride;
    sp_res  = scan_r ? sptr_r : sp_step;
    rem_dec = rem_r - 64'd1;
    done    = (rem_dec == 64'd0) || (soe_r ? eq : !eq);
    {borrow, diff} = {1'b0, a} - {1'b0, b};
    diff    = diff & m;
    flags   = {sign_bit(diff, code_r), (diff == 64'd0), !borrow,
               sign_bit((a ^ b) & (a ^ diff), code_r)};
  end

  // Which popped commands give a result
  always_comb begin
    emit = 1'b0;
    if (pop) begin
      unique case (head_cmd.kind)
        CMD_START_EMPTY: emit = 1'b1;
        CMD_ELEM:        emit = busy_r;
        default:         emit = 1'b0;
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (pop) begin
      unique case (head_cmd.kind)
        CMD_START:       busy_nxt = 1'b1;
        CMD_START_EMPTY: busy_nxt = 1'b0;
        CMD_ELEM:        busy_nxt = busy_r && !done;
        default:         busy_nxt = busy_r;
      endcase
    end
    ov_nxt = emit ? 1'b1 : (out_stall ? ov_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Latch instruction state on a start; advance it on each live element
  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (head_cmd.kind)
        CMD_START, CMD_START_EMPTY: begin
          code_r  <= head_cmd.code;
          scan_r  <= head_cmd.scan;
          soe_r   <= head_cmd.soe;
          rep_r   <= head_cmd.rep;
          back_r  <= head_cmd.back;
          saved_r <= head_cmd.count;
          rem_r   <= head_cmd.rep ? head_cmd.count : 64'd1;
          sptr_r  <= head_cmd.src_addr;
          dptr_r  <= head_cmd.dst_addr;
          acc_r   <= head_cmd.word_a & width_mask(head_cmd.code);
        end
        CMD_ELEM: begin
          if (busy_r) begin
            rem_r  <= rem_dec;
            sptr_r <= sp_res;
            dptr_r <= dp_step;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (head_cmd.kind == CMD_START_EMPTY) begin
        done_r <= 1'b1;
        fw_r   <= 1'b0;
        cl_r   <= head_cmd.count;
        so_r   <= head_cmd.src_addr;
        do_r   <= head_cmd.dst_addr;
        nzcv_r <= 4'd0;
      end else begin
        done_r <= done;
        fw_r   <= done;
        cl_r   <= rep_r ? rem_dec : saved_r;
        so_r   <= sp_res;
        do_r   <= dp_step;
        nzcv_r <= done ? flags : 4'd0;
      end
    end
  end

  assign out_valid         = ov_r;
  assign out_done_res      = done_r;
  assign out_flags_written = fw_r;
  assign out_count_left    = cl_r;
  assign out_src_addr_out  = so_r;
  assign out_dst_addr_out  = do_r;
  assign out_nzcv          = nzcv_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |-> !pop)
    else $error("result overwritten while stalled");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (head_cmd.kind == CMD_START) |=> busy_r)
    else $error("start did not open an instruction");

  a_flags_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !fw_r |-> (nzcv_r == 4'd0))
    else $error("flags present without flags_written");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (busy_r == !done_r))
    else $error("busy disagrees with reported done");

endmodule

FILE: rtl/string_compare_scan_engine_unit.sv
// ---------------------------------------------------------------------------
// string_compare_scan_engine_unit
// Compare-string / scan-string engine with repeat prefixes, NZCV result flags.
// ---------------------------------------------------------------------------
// Path: an item that gives a result passes, after acceptance, through the front
//   register, then the command queue, then the execute/result register, and
//   is taken from there while out_stall is low.
// Throughput: one item per cycle while neither the queue nor the result side
//   stalls; the execute stage computes the 64-bit pointer/count update and compare combinationally.
// Reset: synchronous, active low; clears the idle/busy mark, the queue
//   pointers and all valid flags. No clearing pass is needed.
// ---------------------------------------------------------------------------
module string_compare_scan_engine_unit import scse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [3:0]  in_elem_bytes,
  input  logic        in_is_scan,
  input  logic        in_stop_on_equal,
  input  logic        in_is_rep,
  input  logic        in_backward,
  input  logic [63:0] in_count,
  input  logic [63:0] in_src_addr,
  input  logic [63:0] in_dst_addr,
  input  logic [63:0] in_accumulator,
  input  logic [63:0] in_src_value,
  input  logic [63:0] in_dst_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_done_res,
  output logic        out_flags_written,
  output logic [63:0] out_count_left,
  output logic [63:0] out_src_addr_out,
  output logic [63:0] out_dst_addr_out,
  output logic [3:0]  out_nzcv
);

  // Front end -> queue
  logic    push_valid;
  cmd_t    push_cmd;
  // Queue -> back end
  q_stat_t q_stat;
  cmd_t    head_cmd;
  logic    pop;

  // Front end: register each item and tag it as a start, an empty-repeat
  // start (finishes at once) or an element. Hold while the queue is full.
  scse_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_elem_bytes    (in_elem_bytes),
    .in_is_scan       (in_is_scan),
    .in_stop_on_equal (in_stop_on_equal),
    .in_is_rep        (in_is_rep),
    .in_backward      (in_backward),
    .in_count         (in_count),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_accumulator   (in_accumulator),
    .in_src_value     (in_src_value),
    .in_dst_value     (in_dst_value),
    .q_stat           (q_stat),
    .push_valid       (push_valid),
    .push_cmd         (push_cmd)
  );

  // Two-entry queue decouples front stalls from result-side stalls.
  scse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .q_stat     (q_stat),
    .head_cmd   (head_cmd)
  );

  // Back end: own the instruction state, advance pointers and count per
  // element, drop elements that arrive while idle, and hold the result.
  scse_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .head_cmd          (head_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_done_res      (out_done_res),
    .out_flags_written (out_flags_written),
    .out_count_left    (out_count_left),
    .out_src_addr_out  (out_src_addr_out),
    .out_dst_addr_out  (out_dst_addr_out),
    .out_nzcv          (out_nzcv)
  );

endmodule

FILE: tb/string_compare_scan_engine_unit_tb.sv
// ---------------------------------------------------------------------------
// string_compare_scan_engine_unit_tb
// Self-checking bench for the compare-string / scan-string engine. Directed
// instructions cover zero counts, every element width, both directions,
// pointer wrap, flag corner cases, restarts and ignored elements. Random
// instruction streams then run under three idle/stall mixes. Every result
// item is checked against an in-bench model of the instruction sequencer.
// ---------------------------------------------------------------------------
module string_compare_scan_engine_unit_tb import scse_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = REQ_START;
  logic [3:0]  in_elem_bytes = 4'd1;
  logic        in_is_scan = 1'b0;
  logic        in_stop_on_equal = 1'b0;
  logic        in_is_rep = 1'b0;
  logic        in_backward = 1'b0;
  logic [63:0] in_count = '0;
  logic [63:0] in_src_addr = '0;
  logic [63:0] in_dst_addr = '0;
  logic [63:0] in_accumulator = '0;
  logic [63:0] in_src_value = '0;
  logic [63:0] in_dst_value = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_done_res;
  logic        out_flags_written;
  logic [63:0] out_count_left;
  logic [63:0] out_src_addr_out;
  logic [63:0] out_dst_addr_out;
  logic [3:0]  out_nzcv;

  string_compare_scan_engine_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_elem_bytes     (in_elem_bytes),
    .in_is_scan        (in_is_scan),
    .in_stop_on_equal  (in_stop_on_equal),
    .in_is_rep         (in_is_rep),
    .in_backward       (in_backward),
    .in_count          (in_count),
    .in_src_addr       (in_src_addr),
    .in_dst_addr       (in_dst_addr),
    .in_accumulator    (in_accumulator),
    .in_src_value      (in_src_value),
    .in_dst_value      (in_dst_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_done_res      (out_done_res),
    .out_flags_written (out_flags_written),
    .out_count_left    (out_count_left),
    .out_src_addr_out  (out_src_addr_out),
    .out_dst_addr_out  (out_dst_addr_out),
    .out_nzcv          (out_nzcv)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One reported step of a string instruction, as the result port shows it
  typedef struct packed {
    logic        done;
    logic        flags_wr;
    logic [63:0] count_left;
    logic [63:0] src;
    logic [63:0] dst;
    logic [3:0]  nzcv;
  } string_step_t;

  string_step_t awaited_steps[$];

  int fail_count = 0;
  int modeled_items = 0;       // items that the engine acts on (not ignored)
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  // Model of the running instruction
  logic        run_active = 1'b0;
  wcode_t      run_code = WCODE_B;
  logic        run_scan = 1'b0;
  logic        run_stop_eq = 1'b0;
  logic        run_rep = 1'b0;
  logic        run_back = 1'b0;
  logic [63:0] run_left = '0;
  logic [63:0] run_count0 = '0;
  logic [63:0] run_src = '0;
  logic [63:0] run_dst = '0;
  logic [63:0] run_acc = '0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Bias pointers toward both ends of the address space so wrap gets hit
  function automatic logic [63:0] pick_addr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 64'($urandom_range(0, 31));
    if (sel == 1) return ~64'd0 - 64'($urandom_range(0, 31));
    return rand64();
  endfunction

  // Anything but 1, 2 or 4 bytes runs as a quadword
  function automatic wcode_t code_of_bytes(input logic [3:0] nbytes);
    case (nbytes)
      4'd1:    return WCODE_B;
      4'd2:    return WCODE_W;
      4'd4:    return WCODE_D;
      default: return WCODE_Q;
    endcase
  endfunction

  function automatic logic [63:0] lane_mask(input wcode_t c);
    case (c)
      WCODE_B: return 64'h0000_0000_0000_00ff;
      WCODE_W: return 64'h0000_0000_0000_ffff;
      WCODE_D: return 64'h0000_0000_ffff_ffff;
      default: return 64'hffff_ffff_ffff_ffff;
    endcase
  endfunction

  // NZCV of a - b at the lane width; C set means no borrow
  function automatic logic [3:0] diff_flags(input logic [63:0] a, input logic [63:0] b,
                                            input wcode_t c);
    logic [63:0] diff;
    logic [63:0] ovf;
    int          top;
    top  = (8 << c) - 1;
    diff = (a - b) & lane_mask(c);
    ovf  = (a ^ b) & (a ^ diff);
    return {diff[top], diff == 64'd0, a >= b, ovf[top]};
  endfunction

  // Advance the model by one accepted item and queue the step it reports
  function automatic void model_item(input logic req, input logic [3:0] nbytes,
                                     input logic scan, input logic soe, input logic rep,
                                     input logic back, input logic [63:0] cnt,
                                     input logic [63:0] sa, input logic [63:0] da,
                                     input logic [63:0] acc, input logic [63:0] sv,
                                     input logic [63:0] dv);
    string_step_t step;
    logic [63:0]  m;
    logic [63:0]  stride;
    logic [63:0]  a;
    logic [63:0]  b;
    logic         finished;
    if (req == REQ_START) begin
      // A start always replaces whatever was running
      modeled_items++;
      run_code    = code_of_bytes(nbytes);
      run_scan    = scan;
      run_stop_eq = soe;
      run_rep     = rep;
      run_back    = back;
      run_count0  = cnt;
      run_left    = rep ? cnt : 64'd1;
      run_src     = sa;
      run_dst     = da;
      run_acc     = acc & lane_mask(run_code);
      run_active  = (run_left != 64'd0);
      if (!run_active) begin
        // Repeat with zero count: report at once, flags untouched
        step = '{done: 1'b1, flags_wr: 1'b0, count_left: cnt, src: sa, dst: da,
                 nzcv: 4'd0};
        awaited_steps.push_back(step);
      end
      return;
    end
    if (!run_active) return;   // drop elements that arrive between instructions
    modeled_items++;
    m      = lane_mask(run_code);
    stride = 64'd1 << run_code;
    a      = run_scan ? run_acc : (sv & m);
    b      = dv & m;
    // Scan keeps the source pointer where it was
    if (run_back) begin
      run_dst = run_dst - stride;
      if (!run_scan) run_src = run_src - stride;
    end else begin
      run_dst = run_dst + stride;
      if (!run_scan) run_src = run_src + stride;
    end
    run_left = run_left - 64'd1;
    finished = (run_left == 64'd0) || (run_stop_eq ? (a == b) : (a != b));
    step.done       = finished;
    step.flags_wr   = finished;
    step.count_left = run_rep ? run_left : run_count0;
    step.src        = run_src;
    step.dst        = run_dst;
    step.nzcv       = finished ? diff_flags(a, b, run_code) : 4'd0;
    awaited_steps.push_back(step);
    if (finished) run_active = 1'b0;
  endfunction

  // Offer one item, holding it until the engine takes it, then model it
  task automatic send_item(input logic req, input logic [3:0] nbytes, input logic scan,
                           input logic soe, input logic rep, input logic back,
                           input logic [63:0] cnt, input logic [63:0] sa,
                           input logic [63:0] da, input logic [63:0] acc,
                           input logic [63:0] sv, input logic [63:0] dv);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_elem_bytes    <= nbytes;
    in_is_scan       <= scan;
    in_stop_on_equal <= soe;
    in_is_rep        <= rep;
    in_backward      <= back;
    in_count         <= cnt;
    in_src_addr      <= sa;
    in_dst_addr      <= da;
    in_accumulator   <= acc;
    in_src_value     <= sv;
    in_dst_value     <= dv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_item(req, nbytes, scan, soe, rep, back, cnt, sa, da, acc, sv, dv);
  endtask

  // Start item; element value fields carry noise
  task automatic send_start(input logic [3:0] nbytes, input logic scan, input logic soe,
                            input logic rep, input logic back, input logic [63:0] cnt,
                            input logic [63:0] sa, input logic [63:0] da,
                            input logic [63:0] acc);
    send_item(REQ_START, nbytes, scan, soe, rep, back, cnt, sa, da, acc, rand64(), rand64());
  endtask

  // Element item; instruction fields carry noise
  task automatic send_elem(input logic [63:0] sv, input logic [63:0] dv);
    send_item(REQ_ELEM, 4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), rand64(), rand64(), rand64(), rand64(), sv, dv);
  endtask

  // Drop valid and hold off until every queued step has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_steps.size() != 0) @(posedge clk);
  endtask

  task automatic test_zero_count_and_idle();
    // Repeat with zero count, byte lanes, forward
    send_start(4'd1, 1'b0, 1'b0, 1'b1, 1'b0, 64'd0, 64'd0, ~64'd0, ~64'd0);
    // Nothing running: this element must vanish
    send_elem(~64'd0, 64'd0);
    // Zero count again as a backward quadword scan
    send_start(4'd8, 1'b1, 1'b1, 1'b1, 1'b1, 64'd0, ~64'd0, 64'd0, 64'd0);
  endtask

  task automatic test_widths_and_flags();
    // Bare byte compare at the top of memory: pointers wrap to zero, 0 - 1 borrows
    send_start(4'd1, 1'b0, 1'b0, 1'b0, 1'b0, ~64'd0, ~64'd0, ~64'd0, 64'd0);
    send_elem(64'hffff_ffff_ffff_ff00, 64'h0000_0000_0000_0001);
    // Backward word scan from address zero, stop at the match on the second element
    send_start(4'd2, 1'b1, 1'b1, 1'b1, 1'b1, 64'd5, 64'd0, 64'd1,
               64'hdead_beef_cafe_8000);
    send_elem(~64'd0, 64'h0000_0000_0000_7fff);
    send_elem(64'd0, 64'hffff_ffff_ffff_8000);
    // Dword compare, repeat while equal, ends on a signed overflow
    send_start(4'd4, 1'b0, 1'b0, 1'b1, 1'b0, 64'd4, 64'h1000, 64'h2000, 64'd0);
    send_elem(64'h1234_5678_9abc_def0, 64'hffff_ffff_9abc_def0);
    send_elem(64'h0000_0000_8000_0000, 64'h0000_0000_0000_0001);
    // Quadword compare with the largest count, ends on the first difference
    send_start(4'd8, 1'b0, 1'b0, 1'b1, 1'b0, ~64'd0, 64'h8, 64'h10, 64'd0);
    send_elem(~64'd0, ~64'd0);
    send_elem(64'd0, ~64'd0);
  endtask

  task automatic test_restart_and_bad_width();
    // Abandon a running instruction with a fresh start
    send_start(4'd8, 1'b0, 1'b1, 1'b1, 1'b1, 64'd10, 64'h100, 64'h200, 64'd0);
    send_elem(64'd1, 64'd2);
    // Width 3 runs as a quadword; the count runs out with all elements equal
    send_start(4'd3, 1'b1, 1'b0, 1'b1, 1'b1, 64'd2, 64'h40, 64'h80,
               64'h8000_0000_0000_0000);
    send_elem(64'd0, 64'h8000_0000_0000_0000);
    send_elem(64'd0, 64'h8000_0000_0000_0000);
    // Widths 0 and 15 are quadwords too
    send_start(4'd0, 1'b0, 1'b1, 1'b0, 1'b0, 64'h5555_5555_5555_5555,
               64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, ~64'd0);
    send_elem(~64'd0, ~64'd0);
    send_start(4'd15, 1'b1, 1'b0, 1'b0, 1'b1, 64'd1, 64'd0, 64'd7,
               64'h7fff_ffff_ffff_ffff);
    send_elem(64'd0, ~64'd0);
  endtask

  // Random instruction streams; most run to their natural end, a few get
  // abandoned or separated by stray elements
  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input int goal);
    int          stop_at;
    int          sel;
    int          n_elems;
    logic [3:0]  nbytes;
    logic [63:0] cnt;
    logic [63:0] m;
    logic [63:0] sv;
    logic [63:0] dv;
    logic [63:0] a;
    logic        hit;
    sender_idle_pct = send_pct;
    recv_stall_pct  = stall_pct;
    stop_at = modeled_items + goal;
    while (modeled_items < stop_at) begin
      if ($urandom_range(0, 99) < 4) send_elem(rand64(), rand64());
      if ($urandom_range(0, 99) < 2) hold_until_drained();
      if ($urandom_range(0, 9) == 0) nbytes = 4'($urandom_range(0, 15));
      else nbytes = 4'(1 << $urandom_range(0, 3));
      sel = $urandom_range(0, 99);
      if (sel < 10) cnt = 64'd0;
      else if (sel < 75) cnt = 64'($urandom_range(1, 6));
      else if (sel < 90) cnt = 64'($urandom_range(7, 40));
      else if (sel < 95) cnt = ~64'd0 - 64'($urandom_range(0, 3));
      else cnt = rand64();
      send_start(nbytes, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), cnt,
                 pick_addr(), pick_addr(), rand64());
      n_elems = 0;
      while (run_active && n_elems < 48) begin
        if ($urandom_range(0, 99) < 3) break;
        // Steer equality so both stop conditions and long runs occur
        m   = lane_mask(run_code);
        sv  = rand64();
        a   = run_scan ? run_acc : (sv & m);
        hit = run_stop_eq ? ($urandom_range(0, 99) < 25) : ($urandom_range(0, 99) < 85);
        if (hit) dv = a | (rand64() & ~m);
        else if ($urandom_range(0, 3) == 0) dv = (a + 64'($urandom_range(1, 2))) | (rand64() & ~m);
        else dv = rand64();
        send_elem(sv, dv);
        n_elems++;
      end
    end
  endtask

  initial begin
    sender_idle_pct = 7;
    recv_stall_pct  = 61;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_count_and_idle();
    test_widths_and_flags();
    test_restart_and_bad_width();
    hold_until_drained();
    test_random_traffic(7, 61, 575);
    hold_until_drained();
    test_random_traffic(61, 7, 575);
    hold_until_drained();
    test_random_traffic(0, 0, 575);
    // Drain everything, then give a late stray result a chance to show up
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // Drive the result stall and compare each taken result with the oldest step
  always @(posedge clk) begin : result_check
    string_step_t want;
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_steps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual done %b count %h dst %h",
                 $time, out_done_res, out_count_left, out_dst_addr_out);
        fail_count++;
      end else begin
        want = awaited_steps.pop_front();
        check_field("done_res", 64'(want.done), 64'(out_done_res));
        check_field("flags_written", 64'(want.flags_wr), 64'(out_flags_written));
        check_field("count_left", want.count_left, out_count_left);
        check_field("src_addr_out", want.src, out_src_addr_out);
        check_field("dst_addr_out", want.dst, out_dst_addr_out);
        check_field("nzcv", 64'(want.nzcv), 64'(out_nzcv));
      end
    end
  end

  // Hang detector: any handshake on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
